// File: hdl/dhp6_pkg.sv
// Shared types, constants and helpers for the DHCPv6 header and option parser.
// No dependencies; every other file of the block imports this package.
package dhp6_pkg;

    // Fixed message layout constants.
    localparam logic [15:0] FQDN_CODE  = 16'd39;
    localparam logic [15:0] HDR_BYTES  = 16'd4;
    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int          TDATA_W     = 112;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_HDR  = 2'd0,
        PH_OPTH = 2'd1,
        PH_DATA = 2'd2,
        PH_SKIP = 2'd3
    } phase_t;

    // Result kind codes.
    typedef enum logic [2:0] {
        KIND_HEADER    = 3'd0,
        KIND_BYTE      = 3'd1,
        KIND_COMPLETE  = 3'd2,
        KIND_DROPPED   = 3'd3,
        KIND_DONE      = 3'd4,
        KIND_TRUNC     = 3'd5,
        KIND_MALFORMED = 3'd6
    } kind_t;

    // One queue entry: the up to three results caused by one input byte.
    typedef struct packed {
        logic [1:0]  count;
        kind_t       kind0;
        kind_t       kind1;
        kind_t       kind2;
        logic [7:0]  msg_type;
        logic [23:0] transaction_id;
        logic [15:0] option_code;
        logic [15:0] option_length;
        logic [7:0]  opt_byte;
        logic [15:0] byte_index;
        logic        is_name_byte;
        logic [15:0] consumed_length;
    } entry_t;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Saturate a grown byte count to 16 bits.
    function automatic logic [15:0] sat16(input logic [17:0] s);
        logic [15:0] r;
        begin
            r = (s > 18'h0FFFF) ? 16'hFFFF : s[15:0];
            return r;
        end
    endfunction

endpackage

// File: hdl/dhp6_front.sv
// Front part of the parser: accepts message bytes, tracks header and option
// state and writes one queue entry per byte that causes results. Uses dhp6_pkg.
module dhp6_front
    import dhp6_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_eop,
    input  qstat_t     qstat,
    output logic       in_ready,
    output logic       push,
    output entry_t     push_entry
);

    phase_t      phase_reg,  phase_next;
    logic [1:0]  fcnt_reg,   fcnt_next;
    logic [7:0]  type_reg,   type_next;
    logic [23:0] txn_reg,    txn_next;
    logic [15:0] code_reg,   code_next;
    logic [15:0] len_reg,    len_next;
    logic [15:0] didx_reg,   didx_next;
    logic [15:0] cons_reg,   cons_next;
    logic        finish;
    logic        accept;
    entry_t      e;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && !qstat.full;

    // Parse one byte: next state and the results it causes.
    always_comb
    begin
        phase_next = phase_reg;
        fcnt_next  = fcnt_reg;
        type_next  = type_reg;
        txn_next   = txn_reg;
        code_next  = code_reg;
        len_next   = len_reg;
        didx_next  = didx_reg;
        cons_next  = cons_reg;
        finish     = 1'b0;
        e          = '0;
        e.kind0    = KIND_HEADER;
        e.kind1    = KIND_HEADER;
        e.kind2    = KIND_HEADER;
        case (phase_reg)
            PH_HDR:
            begin
                if (fcnt_reg == 2'd0)
                begin
                    type_next = in_byte;
                end
                else
                begin
                    txn_next = {txn_reg[15:0], in_byte};
                end
                if (fcnt_reg == 2'd3)
                begin
                    fcnt_next = 2'd0;
                    if (type_reg == 8'd0)
                    begin
                        e.count    = 2'd1;
                        e.kind0    = KIND_MALFORMED;
                        phase_next = PH_SKIP;
                        finish     = in_eop;
                    end
                    else
                    begin
                        e.count            = 2'd1;
                        e.kind0            = KIND_HEADER;
                        e.msg_type         = type_reg;
                        e.transaction_id   = txn_next;
                        e.consumed_length  = HDR_BYTES;
                        cons_next          = HDR_BYTES;
                        code_next          = '0;
                        len_next           = '0;
                        phase_next         = PH_OPTH;
                        if (in_eop)
                        begin
                            e.count = 2'd2;
                            e.kind1 = KIND_DONE;
                            finish  = 1'b1;
                        end
                    end
                end
                else
                begin
                    fcnt_next = fcnt_reg + 2'd1;
                    if (in_eop)
                    begin
                        e.count = 2'd1;
                        e.kind0 = KIND_TRUNC;
                        finish  = 1'b1;
                    end
                end
            end
            PH_OPTH:
            begin
                if (fcnt_reg < 2'd2)
                begin
                    code_next = {code_reg[7:0], in_byte};
                end
                else
                begin
                    len_next = {len_reg[7:0], in_byte};
                end
                e.option_code   = code_next;
                e.option_length = len_next;
                if (fcnt_reg == 2'd3)
                begin
                    fcnt_next = 2'd0;
                    if (len_next == 16'd0)
                    begin
                        e.count   = 2'd1;
                        e.kind0   = KIND_COMPLETE;
                        cons_next = sat16({2'b00, cons_reg} + 18'd4);
                        code_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                        didx_next  = '0;
                        if (in_eop)
                        begin
                            e.count = 2'd1;
                            e.kind0 = KIND_DROPPED;
                        end
                    end
                end
                else
                begin
                    fcnt_next = fcnt_reg + 2'd1;
                    if (in_eop)
                    begin
                        // Partial option header: missing low bytes read as zero.
                        if (fcnt_reg == 2'd0)
                        begin
                            e.option_code = {code_next[7:0], 8'h00};
                        end
                        if (fcnt_reg == 2'd2)
                        begin
                            e.option_length = {len_next[7:0], 8'h00};
                        end
                        e.count = 2'd1;
                        e.kind0 = KIND_DROPPED;
                    end
                end
                if (in_eop)
                begin
                    e.consumed_length = cons_next;
                    finish            = 1'b1;
                    if (e.count == 2'd0)
                    begin
                        e.kind0 = KIND_DONE;
                    end
                    else
                    begin
                        e.kind1 = KIND_DONE;
                    end
                    e.count = e.count + 2'd1;
                end
            end
            PH_DATA:
            begin
                e.count          = 2'd1;
                e.kind0          = KIND_BYTE;
                e.option_code    = code_reg;
                e.option_length  = len_reg;
                e.opt_byte       = in_byte;
                e.byte_index     = didx_reg;
                e.is_name_byte   = (code_reg == FQDN_CODE) && (didx_reg != 16'd0);
                if (({1'b0, didx_reg} + 17'd1) >= {1'b0, len_reg})
                begin
                    e.count    = 2'd2;
                    e.kind1    = KIND_COMPLETE;
                    cons_next  = sat16({2'b00, cons_reg} + {2'b00, len_reg} + 18'd4);
                    code_next  = '0;
                    len_next   = '0;
                    didx_next  = '0;
                    phase_next = PH_OPTH;
                end
                else
                begin
                    didx_next = didx_reg + 16'd1;
                    if (in_eop)
                    begin
                        e.count = 2'd2;
                        e.kind1 = KIND_DROPPED;
                    end
                end
                if (in_eop)
                begin
                    e.count           = 2'd3;
                    e.kind2           = KIND_DONE;
                    e.consumed_length = cons_next;
                    finish            = 1'b1;
                end
            end
            default:
            begin
                finish = in_eop;
            end
        endcase
    end

    assign push       = accept && (e.count != 2'd0);
    assign push_entry = e;

    // Parser state; packet end returns everything to its reset value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            fcnt_reg  <= '0;
            type_reg  <= '0;
            txn_reg   <= '0;
            code_reg  <= '0;
            len_reg   <= '0;
            didx_reg  <= '0;
            cons_reg  <= '0;
        end
        else if (accept)
        begin
            if (finish)
            begin
                phase_reg <= PH_HDR;
                fcnt_reg  <= '0;
                type_reg  <= '0;
                txn_reg   <= '0;
                code_reg  <= '0;
                len_reg   <= '0;
                didx_reg  <= '0;
                cons_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                fcnt_reg  <= fcnt_next;
                type_reg  <= type_next;
                txn_reg   <= txn_next;
                code_reg  <= code_next;
                len_reg   <= len_next;
                didx_reg  <= didx_next;
                cons_reg  <= cons_next;
            end
        end
    end

endmodule

// File: hdl/dhp6_queue.sv
// Short entry queue between the front and back parts of the parser.
// Register-based, QUEUE_DEPTH entries; uses dhp6_pkg.
module dhp6_queue
    import dhp6_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output qstat_t qstat
);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QPTR_W:0]     cnt_reg;
    logic                do_push;
    logic                do_pop;

    assign qstat.full  = (cnt_reg == QUEUE_DEPTH[QPTR_W:0]);
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = slot_reg[rptr_reg];

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/dhp6_back.sv
// Back part of the parser: takes queue entries and sends their results one
// transfer at a time on the output stream. Uses dhp6_pkg.
module dhp6_back
    import dhp6_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  entry_t             head,
    input  qstat_t             qstat,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         out_kind,
    output logic [TDATA_W-1:0] out_data,
    output logic               out_last
);

    entry_t     cur_reg;
    logic       valid_reg;
    logic [1:0] sel_reg;
    kind_t      kind;
    logic       is_last;
    logic       xfer;
    logic       hdr_k;
    logic       opt_k;
    logic       byte_k;
    logic       done_k;

    // Pick the result of the held entry.
    always_comb
    begin
        case (sel_reg)
            2'd0:    kind = cur_reg.kind0;
            2'd1:    kind = cur_reg.kind1;
            2'd2:    kind = cur_reg.kind2;
            default: kind = cur_reg.kind0;
        endcase
    end

    assign is_last = (sel_reg == (cur_reg.count - 2'd1));
    assign xfer    = valid_reg && out_ready;
    assign pop     = (!valid_reg || (xfer && is_last)) && !qstat.empty;

    // Fields not belonging to the current kind read as zero.
    assign hdr_k  = (kind == KIND_HEADER);
    assign byte_k = (kind == KIND_BYTE);
    assign opt_k  = byte_k || (kind == KIND_COMPLETE) || (kind == KIND_DROPPED);
    assign done_k = (kind == KIND_DONE);

    assign out_valid = valid_reg;
    assign out_kind  = kind;
    assign out_last  = is_last;
    assign out_data  = {
        7'd0,
        done_k ? cur_reg.consumed_length : 16'd0,
        byte_k & cur_reg.is_name_byte,
        byte_k ? cur_reg.byte_index : 16'd0,
        byte_k ? cur_reg.opt_byte : 8'd0,
        opt_k  ? cur_reg.option_length : 16'd0,
        opt_k  ? cur_reg.option_code : 16'd0,
        hdr_k  ? cur_reg.transaction_id : 24'd0,
        hdr_k  ? cur_reg.msg_type : 8'd0
    };

    // Entry payload register.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
    end

    // Output valid and result selector.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= '0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            sel_reg   <= '0;
        end
        else if (xfer && is_last)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= '0;
        end
        else if (xfer)
        begin
            sel_reg <= sel_reg + 2'd1;
        end
    end

endmodule

// File: hdl/dhcpv6_header_option_parser.sv
// DHCPv6 header and option parser, one message byte per input transfer.
// With the queue empty, a byte's entry is registered in the queue, then in the output register.
// Throughput: one byte per cycle while the queue is not full; each byte yields up to three
// output transfers, one per cycle while m_tready is high; a four-entry queue absorbs those bursts.
// Reset (rst_n low, asynchronous) returns the parser to the header phase and
// empties the queue and the output register.
module dhcpv6_header_option_parser
    import dhp6_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // end_of_packet
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] msg_type, [31:8] transaction_id, [47:32] option_code,
    // [63:48] option_length, [71:64] option_byte, [87:72] byte_index,
    // [88] is_name_byte, [104:89] consumed_length, [111:105] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [2:0]         m_tuser,   // [2:0] kind
    output logic               m_tlast    // last
);

    qstat_t qstat;
    logic   push;
    logic   pop;
    entry_t push_entry;
    entry_t head;

    dhp6_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_eop     (s_tlast),
        .qstat      (qstat),
        .in_ready   (s_tready),
        .push       (push),
        .push_entry (push_entry)
    );

    dhp6_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    dhp6_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// File: tb/sv/dhcpv6_result_checker.sv
// Result checker for the DHCPv6 header and option parser testbench.
// Watches both stream channels, predicts the results of every byte and compares them.
// Depends on dhp6_pkg for the phase and kind enums and the message constants.
`timescale 1ns / 1ps

module dhcpv6_result_checker
    import dhp6_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // end_of_packet
    input  logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] msg_type, [31:8] transaction_id, [47:32] option_code,
    // [63:48] option_length, [71:64] option_byte, [87:72] byte_index,
    // [88] is_name_byte, [104:89] consumed_length, [111:105] zero
    input  logic [TDATA_W-1:0] m_tdata,
    input  logic [2:0]         m_tuser,   // [2:0] kind
    input  logic               m_tlast,
    output int                 errors,
    output int                 pending,
    output int                 bytes_taken,
    output int                 results_checked,
    output logic [6:0]         kinds_hit
);

    // One predicted result, in the order of the output fields.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  msg_type;
        logic [23:0] txn_id;
        logic [15:0] code;
        logic [15:0] len;
        logic [7:0]  opt_byte;
        logic [15:0] index;
        logic        name_byte;
        logic [15:0] consumed;
        logic        tail;
    } parse_result_t;

    // Results predicted but not yet seen on the output channel.
    parse_result_t parse_results_due[$];

    // Parser state as the checker sees it.
    phase_t      ph;
    logic [1:0]  field_cnt;
    logic [7:0]  type_r;
    logic [23:0] txn_r;
    logic [15:0] code_r;
    logic [15:0] len_r;
    logic [15:0] idx_r;
    logic [15:0] consumed_r;

    task automatic report(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        errors++;
    endtask

    task automatic clear_parser();
        ph         = PH_HDR;
        field_cnt  = 2'd0;
        type_r     = 8'h00;
        txn_r      = 24'h0;
        code_r     = 16'h0;
        len_r      = 16'h0;
        idx_r      = 16'h0;
        consumed_r = 16'h0;
    endtask

    function automatic parse_result_t result_of(
        input kind_t k, input logic [7:0] mt, input logic [23:0] tid,
        input logic [15:0] c, input logic [15:0] l, input logic [7:0] ob,
        input logic [15:0] ix, input logic nm, input logic [15:0] cons);
        parse_result_t r;
        r = '{kind: k, msg_type: mt, txn_id: tid, code: c, len: l, opt_byte: ob,
              index: ix, name_byte: nm, consumed: cons, tail: 1'b0};
        return r;
    endfunction

    // Append one prediction at the end of the pending list.
    task automatic add_due(input parse_result_t r);
        parse_results_due.insert(parse_results_due.size(), r);
    endtask

    // The consumed count sticks at its maximum rather than wrapping.
    task automatic add_consumed(input logic [16:0] amount);
        logic [17:0] sum;
        sum = {2'b00, consumed_r} + {1'b0, amount};
        consumed_r = (sum > 18'h0FFFF) ? 16'hFFFF : sum[15:0];
    endtask

    // Advance the parser by one message byte and queue the results it causes.
    task automatic parse_byte(input logic [7:0] b, input logic eop);
        int          first;
        bit          finish;
        logic [15:0] c;
        logic [15:0] l;
        first  = parse_results_due.size();
        finish = 1'b0;
        case (ph)
            PH_HDR:
            begin
                if (field_cnt == 2'd0)
                    type_r = b;
                else
                    txn_r = {txn_r[15:0], b};
                if (field_cnt == 2'd3)
                begin
                    field_cnt = 2'd0;
                    if (type_r == 8'h00)
                    begin
                        // A zero message type discards the rest of the packet.
                        add_due(result_of(KIND_MALFORMED, '0, '0, '0, '0, '0, '0, '0, '0));
                        ph     = PH_SKIP;
                        finish = eop;
                    end
                    else
                    begin
                        add_due(result_of(KIND_HEADER, type_r, txn_r,
                                          '0, '0, '0, '0, '0, '0));
                        consumed_r = HDR_BYTES;
                        code_r     = 16'h0;
                        len_r      = 16'h0;
                        ph         = PH_OPTH;
                        if (eop)
                        begin
                            add_due(result_of(KIND_DONE, '0, '0, '0, '0,
                                              '0, '0, '0, consumed_r));
                            finish = 1'b1;
                        end
                    end
                end
                else
                begin
                    field_cnt = field_cnt + 2'd1;
                    if (eop)
                    begin
                        add_due(result_of(KIND_TRUNC, '0, '0, '0, '0, '0, '0, '0, '0));
                        finish = 1'b1;
                    end
                end
            end

            PH_OPTH:
            begin
                if (field_cnt < 2'd2)
                    code_r = {code_r[7:0], b};
                else
                    len_r = {len_r[7:0], b};
                if (field_cnt == 2'd3)
                begin
                    field_cnt = 2'd0;
                    if (len_r == 16'h0)
                    begin
                        add_due(result_of(KIND_COMPLETE, '0, '0, code_r,
                                          '0, '0, '0, '0, '0));
                        add_consumed(17'd4);
                        code_r = 16'h0;
                    end
                    else
                    begin
                        ph    = PH_DATA;
                        idx_r = 16'h0;
                        if (eop)
                            add_due(result_of(KIND_DROPPED, '0, '0,
                                              code_r, len_r, '0, '0, '0, '0));
                    end
                end
                else
                begin
                    field_cnt = field_cnt + 2'd1;
                    if (eop)
                    begin
                        // A half-read code or length has its missing low byte as zero.
                        c = code_r;
                        l = len_r;
                        if (field_cnt == 2'd1)
                            c = {code_r[7:0], 8'h00};
                        if (field_cnt == 2'd3)
                            l = {len_r[7:0], 8'h00};
                        add_due(result_of(KIND_DROPPED, '0, '0, c, l, '0, '0, '0, '0));
                    end
                end
                if (eop)
                begin
                    add_due(result_of(KIND_DONE, '0, '0, '0, '0, '0, '0, '0, consumed_r));
                    finish = 1'b1;
                end
            end

            PH_DATA:
            begin
                add_due(result_of(KIND_BYTE, '0, '0, code_r, len_r, b, idx_r,
                                  code_r == FQDN_CODE && idx_r != 16'h0, '0));
                if ({1'b0, idx_r} + 17'd1 >= {1'b0, len_r})
                begin
                    add_due(result_of(KIND_COMPLETE, '0, '0, code_r,
                                      len_r, '0, '0, '0, '0));
                    add_consumed(17'd4 + {1'b0, len_r});
                    code_r = 16'h0;
                    len_r  = 16'h0;
                    idx_r  = 16'h0;
                    ph     = PH_OPTH;
                end
                else
                begin
                    idx_r = idx_r + 16'd1;
                    if (eop)
                        add_due(result_of(KIND_DROPPED, '0, '0, code_r,
                                          len_r, '0, '0, '0, '0));
                end
                if (eop)
                begin
                    add_due(result_of(KIND_DONE, '0, '0, '0, '0, '0, '0, '0, consumed_r));
                    finish = 1'b1;
                end
            end

            default:
                finish = eop;
        endcase

        if (parse_results_due.size() > first)
            parse_results_due[parse_results_due.size() - 1].tail = 1'b1;
        if (finish)
            clear_parser();
    endtask

    task automatic match(input string field, input logic [23:0] got,
                         input logic [23:0] want);
        if (got !== want)
            report($sformatf("%s is 0x%0h, expected 0x%0h", field, got, want));
    endtask

    // Compare one output transfer with the oldest prediction.
    task automatic check_result();
        parse_result_t want;
        results_checked++;
        if (m_tuser < 3'd7)
            kinds_hit[m_tuser] = 1'b1;
        if (parse_results_due.size() == 0)
        begin
            report($sformatf("result of kind %0d arrived with nothing expected", m_tuser));
            return;
        end
        want = parse_results_due.pop_front();
        match("kind", m_tuser, want.kind);
        match("msg_type", m_tdata[7:0], want.msg_type);
        match("transaction_id", m_tdata[31:8], want.txn_id);
        match("option_code", m_tdata[47:32], want.code);
        match("option_length", m_tdata[63:48], want.len);
        match("option_byte", m_tdata[71:64], want.opt_byte);
        match("byte_index", m_tdata[87:72], want.index);
        match("is_name_byte", m_tdata[88], want.name_byte);
        match("consumed_length", m_tdata[104:89], want.consumed);
        match("padding", m_tdata[111:105], 24'h0);
        match("last", m_tlast, want.tail);
    endtask

    // Outputs are checked before the byte of the same edge is parsed; that byte
    // cannot have produced a result yet.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parser();
            parse_results_due.delete();
            errors          = 0;
            bytes_taken     = 0;
            results_checked = 0;
            kinds_hit       = 7'b0;
            pending        <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
            begin
                bytes_taken++;
                parse_byte(s_tdata, s_tlast);
            end
            pending <= parse_results_due.size();
        end
    end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the DHCPv6 header and option parser: clock, reset and stimulus.
// Instantiates the parser and dhcpv6_result_checker, and gives the verdict.
// Depends on dhp6_pkg and on the checker module.
`timescale 1ns / 1ps

module tb
    import dhp6_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 23;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = 8'h00;   // [7:0] data_byte
    logic               s_tlast = 1'b0;    // end_of_packet
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    // [7:0] msg_type, [31:8] transaction_id, [47:32] option_code,
    // [63:48] option_length, [71:64] option_byte, [87:72] byte_index,
    // [88] is_name_byte, [104:89] consumed_length, [111:105] zero
    logic [TDATA_W-1:0] m_tdata;
    logic [2:0]         m_tuser;           // [2:0] kind
    logic               m_tlast;

    int          errors;
    int          pending;
    int          bytes_taken;
    int          results_checked;
    logic [6:0]  kinds_hit;

    int unsigned sender_idle = 0;
    int unsigned recv_stall = 0;
    logic        hold = 1'b0;
    logic        press_go = 1'b0;
    int          cycle_count = 0;
    logic [7:0]  pkt[$];

    always #1 clk = ~clk;

    dhcpv6_header_option_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    dhcpv6_result_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .errors          (errors),
        .pending         (pending),
        .bytes_taken     (bytes_taken),
        .results_checked (results_checked),
        .kinds_hit       (kinds_hit)
    );

    // Receiver: random stalls, plus the long hold-off while hold is set.
    always @(posedge clk)
        m_tready <= !hold && ($urandom_range(99) >= recv_stall);

    // One long hold-off on the output so that the queue fills and the input stalls.
    initial
    begin
        wait (press_go);
        hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold <= 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("FAIL dhcpv6_header_option_parser");
            $finish;
        end
    end

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        sender_idle = send_pct;
        recv_stall <= recv_pct;
    endtask

    // Append one byte to the packet being built.
    task automatic add_byte(input logic [7:0] b);
        pkt.insert(pkt.size(), b);
    endtask

    // Offer one byte and wait for its transfer.
    task automatic send_byte(input logic [7:0] b, input logic eop);
        while ($urandom_range(99) < sender_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eop;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    // Mostly well-formed messages with random options, some cut short,
    // and a share of short or arbitrary byte runs.
    task automatic make_random_packet();
        int          sel;
        int          n_opts;
        int          len;
        int          n_data;
        int          cut;
        int          i;
        logic [15:0] code;
        pkt.delete();
        sel = $urandom_range(99);
        if (sel < 15)
        begin
            repeat ($urandom_range(1, 7)) add_byte(8'($urandom_range(255)));
            return;
        end
        add_byte(sel < 20 ? 8'h00 : 8'($urandom_range(1, 255)));
        repeat (3) add_byte(8'($urandom_range(255)));
        n_opts = $urandom_range(0, 3);
        for (i = 0; i < n_opts; i++)
        begin
            code = ($urandom_range(3) == 0) ? FQDN_CODE : 16'($urandom_range(65535));
            len  = ($urandom_range(9) < 7) ? $urandom_range(0, 5)
                                           : $urandom_range(6, 65535);
            add_byte(code[15:8]);
            add_byte(code[7:0]);
            add_byte(8'(len >> 8));
            add_byte(8'(len));
            n_data = (len < 6) ? len : $urandom_range(1, 4);
            repeat (n_data) add_byte(8'($urandom_range(255)));
            // A long option that runs past the packet end is always dropped.
            if (n_data < len)
                break;
        end
        if (pkt.size() > 4 && $urandom_range(3) == 0)
        begin
            cut = $urandom_range(5, pkt.size());
            while (pkt.size() > cut)
                void'(pkt.pop_back());
        end
    endtask

    initial
    begin
        int phase;
        int phase_bytes;
        int random_bytes;

        random_bytes = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed messages, no idling.
        set_idling(0, 0);
        // Extreme header, name option, then a zero-length option on the end byte.
        pkt = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h27, 8'h00, 8'h02, 8'h00, 8'hFF,
                8'hFF, 8'hFF, 8'h00, 8'h00};
        send_packet();
        // Header alone, ended on its fourth byte.
        pkt = '{8'h01, 8'h00, 8'h00, 8'h00};
        send_packet();
        // Short header with a zero type byte.
        pkt = '{8'h00, 8'h00};
        send_packet();
        // Zero type, followed by a byte that is skipped.
        pkt = '{8'h00, 8'h12, 8'h34, 8'h56, 8'hAA};
        send_packet();
        // Option cut after one code byte.
        pkt = '{8'h05, 8'h00, 8'h00, 8'h01, 8'h12};
        send_packet();
        // Option cut after three header bytes.
        pkt = '{8'h03, 8'h01, 8'h02, 8'h03, 8'h12, 8'h34, 8'h56};
        send_packet();
        // Name option cut inside its data.
        pkt = '{8'h07, 8'hAB, 8'hCD, 8'hEF, 8'h00, 8'h27, 8'h00, 8'h05, 8'h61, 8'h62};
        send_packet();

        // Random messages under each idling pattern; the first also carries
        // the long output hold-off.
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    set_idling(0, 0);
                    press_go <= 1'b1;
                end
                1: set_idling(85, 0);
                2: set_idling(0, 85);
                default: set_idling(35, 35);
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                make_random_packet();
                send_packet();
                phase_bytes += pkt.size();
            end
            random_bytes += phase_bytes;
        end

        s_tvalid <= 1'b0;
        set_idling(0, 0);
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Run took %0d message bytes (%0d random) and checked %0d results.",
                 bytes_taken, random_bytes, results_checked);
        $display("Result kinds seen, highest first: %07b; %0d mismatches.",
                 kinds_hit, errors);
        if (errors == 0 && pending == 0)
            $display("PASS dhcpv6_header_option_parser");
        else
            $display("FAIL dhcpv6_header_option_parser");
        $finish;
    end

endmodule
